@@ sv/iaz_pkg.sv @@
// ----------------------------------------------------------------------------
// iaz_pkg - shared types and codes for the 64-bit integer ALU
// Operation codes, operation classes and the queue entry layout.
// ----------------------------------------------------------------------------
package iaz_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned FuncW = 5;

  localparam logic [FuncW-1:0] FN_ADD  = 5'd0;
  localparam logic [FuncW-1:0] FN_SUB  = 5'd1;
  localparam logic [FuncW-1:0] FN_MUL  = 5'd2;
  localparam logic [FuncW-1:0] FN_UDIV = 5'd3;
  localparam logic [FuncW-1:0] FN_SDIV = 5'd4;
  localparam logic [FuncW-1:0] FN_UREM = 5'd5;
  localparam logic [FuncW-1:0] FN_SREM = 5'd6;
  localparam logic [FuncW-1:0] FN_EQ   = 5'd7;
  localparam logic [FuncW-1:0] FN_SLT  = 5'd8;
  localparam logic [FuncW-1:0] FN_SGT  = 5'd9;
  localparam logic [FuncW-1:0] FN_ULT  = 5'd10;
  localparam logic [FuncW-1:0] FN_UGT  = 5'd11;
  localparam logic [FuncW-1:0] FN_SHL  = 5'd12;
  localparam logic [FuncW-1:0] FN_SHR  = 5'd13;
  localparam logic [FuncW-1:0] FN_AND  = 5'd14;
  localparam logic [FuncW-1:0] FN_XOR  = 5'd15;
  localparam logic [FuncW-1:0] FN_OR   = 5'd16;
  localparam logic [FuncW-1:0] FN_NOT  = 5'd17;

  // operation class, set by the front end
  typedef enum logic [2:0] {
    CLS_ALU,   // add, subtract, shift and logic
    CLS_MUL,   // split multiply
    CLS_DIV,   // iterative divide or remainder
    CLS_DZ,    // divide or remainder by zero
    CLS_CMP,   // compare, flag only
    CLS_NONE   // unused code, all-zero result
  } cls_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    cls_t             cls;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } q_entry_t;

  typedef struct packed {
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic             sgn;
    logic             want_rem;
  } div_req_t;

endpackage

@@ sv/iaz_front.sv @@
// ----------------------------------------------------------------------------
// iaz_front - accept and classify
// Decodes each input beat into an operation class and queues it.
// ----------------------------------------------------------------------------
module iaz_front #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [iaz_pkg::FuncW-1:0]      in_func,
  input  logic [iaz_pkg::DataW-1:0]      in_a,
  input  logic [iaz_pkg::DataW-1:0]      in_b,
  output logic                           q_valid,
  input  logic                           q_pop,
  output iaz_pkg::q_entry_t              q_head
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  iaz_pkg::q_entry_t mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  iaz_pkg::cls_t     cls;
  logic              push;

  always_comb begin
    case (in_func) inside
      iaz_pkg::FN_MUL: cls = iaz_pkg::CLS_MUL;
      iaz_pkg::FN_UDIV, iaz_pkg::FN_SDIV, iaz_pkg::FN_UREM, iaz_pkg::FN_SREM: begin
        cls = (in_b == '0) ? iaz_pkg::CLS_DZ : iaz_pkg::CLS_DIV;
      end
      [iaz_pkg::FN_EQ:iaz_pkg::FN_UGT]: cls = iaz_pkg::CLS_CMP;
      iaz_pkg::FN_ADD, iaz_pkg::FN_SUB, [iaz_pkg::FN_SHL:iaz_pkg::FN_NOT]: begin
        cls = iaz_pkg::CLS_ALU;
      end
      default: cls = iaz_pkg::CLS_NONE;
    endcase
  end

  assign in_ready = (cnt_r != FullCnt);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == LastPtr) ? '0 : wptr_r + 1'b1;
    end
    if (q_pop) begin
      rptr_nxt = (rptr_r == LastPtr) ? '0 : rptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= '{func: in_func, cls: cls, a: in_a, b: in_b};
    end
  end

endmodule

@@ sv/iaz_div.sv @@
// ----------------------------------------------------------------------------
// iaz_div - iterative 64-bit divider
// Restoring division, one quotient bit per cycle, signs fixed at the end.
// ----------------------------------------------------------------------------
module iaz_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  iaz_pkg::div_req_t            req,
  output logic                         idle,
  output logic                         done,
  input  logic                         ack,
  output logic [iaz_pkg::DataW-1:0]    result
);

  localparam int unsigned W    = iaz_pkg::DataW;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] LastCnt = CntW'(W - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } dstate_t;

  dstate_t         st_r, st_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]    quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic            negq_r, negq_nxt, negr_r, negr_nxt, wrem_r, wrem_nxt;
  logic [W:0]      trial;
  logic            ge;
  logic [W-1:0]    mag_a, mag_b, pick;
  logic            pick_neg;

  assign mag_a = (req.sgn && req.a[W-1]) ? (~req.a + 1'b1) : req.a;
  assign mag_b = (req.sgn && req.b[W-1]) ? (~req.b + 1'b1) : req.b;
  assign trial = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};
  assign ge    = !trial[W];

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    wrem_nxt = wrem_r;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          st_nxt   = ST_RUN;
          cnt_nxt  = '0;
          quo_nxt  = mag_a;
          rem_nxt  = '0;
          dvs_nxt  = mag_b;
          negq_nxt = req.sgn && (req.a[W-1] ^ req.b[W-1]);
          negr_nxt = req.sgn && req.a[W-1];
          wrem_nxt = req.want_rem;
        end
      end
      ST_RUN: begin
        rem_nxt = ge ? trial[W-1:0] : {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LastCnt) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
    wrem_r <= wrem_nxt;
  end

  assign pick     = wrem_r ? rem_r : quo_r;
  assign pick_neg = wrem_r ? negr_r : negq_r;
  assign result   = pick_neg ? (~pick + 1'b1) : pick;
  assign idle     = (st_r == ST_IDLE);
  assign done     = (st_r == ST_DONE);

endmodule

@@ sv/iaz_back.sv @@
// ----------------------------------------------------------------------------
// iaz_back - execute
// Two-stage execute pipe whose second stage is the output register; divides go to iaz_div.
// ----------------------------------------------------------------------------
module iaz_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  iaz_pkg::q_entry_t            q_head,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [iaz_pkg::DataW-1:0]    out_result,
  output logic                         out_wb,
  output logic                         out_zf,
  output logic                         out_dz
);

  localparam int unsigned W = iaz_pkg::DataW;
  localparam int unsigned H = W / 2;

  // stage 1 registers
  logic         e1_v_r, e1_v_nxt;
  logic         e1_mul_r, e1_wb_r, e1_dz_r, e1_zfix_r, e1_zval_r;
  logic [W-1:0] e1_val_r;
  logic [H-1:0] e1_p1_r, e1_p2_r;
  // output registers
  logic         o_v_r, o_v_nxt;
  logic [W-1:0] o_res_r;
  logic         o_wb_r, o_zf_r, o_dz_r;

  logic              e2_load, e1_free, is_div, div_start, div_take;
  logic              div_idle, div_done;
  logic [W-1:0]      div_res, alu_val, a, b, fin;
  logic              cond;
  iaz_pkg::div_req_t dreq;

  assign a = q_head.a;
  assign b = q_head.b;

  assign e2_load   = e1_v_r && (!o_v_r || out_ready);
  assign e1_free   = !e1_v_r || e2_load;
  assign is_div    = (q_head.cls == iaz_pkg::CLS_DIV);
  assign div_take  = div_done && e1_free;
  // a busy divider blocks the queue so results stay in order
  assign div_start = q_valid && is_div && div_idle;
  assign q_pop     = div_start || (q_valid && !is_div && div_idle && e1_free);

  assign dreq.a        = a;
  assign dreq.b        = b;
  assign dreq.sgn      = (q_head.func == iaz_pkg::FN_SDIV) || (q_head.func == iaz_pkg::FN_SREM);
  assign dreq.want_rem = (q_head.func == iaz_pkg::FN_UREM) || (q_head.func == iaz_pkg::FN_SREM);

  iaz_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .req    (dreq),
    .idle   (div_idle),
    .done   (div_done),
    .ack    (div_take),
    .result (div_res)
  );

  always_comb begin
    case (q_head.func)
      iaz_pkg::FN_ADD: alu_val = a + b;
      iaz_pkg::FN_SUB: alu_val = a - b;
      iaz_pkg::FN_SHL: alu_val = (|b[W-1:6]) ? '0 : (a << b[5:0]);
      iaz_pkg::FN_SHR: alu_val = (|b[W-1:6]) ? '0 : (a >> b[5:0]);
      iaz_pkg::FN_AND: alu_val = a & b;
      iaz_pkg::FN_XOR: alu_val = a ^ b;
      iaz_pkg::FN_OR:  alu_val = a | b;
      iaz_pkg::FN_NOT: alu_val = ~a;
      default:         alu_val = '0;
    endcase
  end

  always_comb begin
    case (q_head.func)
      iaz_pkg::FN_EQ:  cond = (a == b);
      iaz_pkg::FN_SLT: cond = ({~a[W-1], a[W-2:0]} < {~b[W-1], b[W-2:0]});
      iaz_pkg::FN_SGT: cond = ({~b[W-1], b[W-2:0]} < {~a[W-1], a[W-2:0]});
      iaz_pkg::FN_ULT: cond = (a < b);
      iaz_pkg::FN_UGT: cond = (a > b);
      default:         cond = 1'b0;
    endcase
  end

  assign e1_v_nxt = div_take || (q_pop && !is_div) || (e1_v_r && !e2_load);

  always_ff @(posedge clk) begin
    if (div_take) begin
      e1_mul_r  <= 1'b0;
      e1_val_r  <= div_res;
      e1_wb_r   <= 1'b1;
      e1_dz_r   <= 1'b0;
      e1_zfix_r <= 1'b0;
      e1_zval_r <= 1'b0;
    end else if (q_pop && !is_div) begin
      e1_mul_r  <= (q_head.cls == iaz_pkg::CLS_MUL);
      e1_dz_r   <= (q_head.cls == iaz_pkg::CLS_DZ);
      e1_wb_r   <= (q_head.cls != iaz_pkg::CLS_CMP) && (q_head.cls != iaz_pkg::CLS_NONE);
      e1_zfix_r <= (q_head.cls == iaz_pkg::CLS_CMP) || (q_head.cls == iaz_pkg::CLS_NONE);
      e1_zval_r <= (q_head.cls == iaz_pkg::CLS_CMP) && cond;
      // low product plus the two cross terms; only their low halves matter
      if (q_head.cls == iaz_pkg::CLS_MUL) begin
        e1_val_r <= a[H-1:0] * b[H-1:0];
      end else if (q_head.cls == iaz_pkg::CLS_ALU) begin
        e1_val_r <= alu_val;
      end else begin
        e1_val_r <= '0;
      end
      e1_p1_r <= H'(a[H-1:0] * b[W-1:H]);
      e1_p2_r <= H'(a[W-1:H] * b[H-1:0]);
    end
  end

  assign fin     = e1_mul_r ? (e1_val_r + {e1_p1_r + e1_p2_r, {H{1'b0}}}) : e1_val_r;
  assign o_v_nxt = e2_load || (o_v_r && !out_ready);

  always_ff @(posedge clk) begin
    if (e2_load) begin
      o_res_r <= fin;
      o_wb_r  <= e1_wb_r;
      o_dz_r  <= e1_dz_r;
      o_zf_r  <= e1_zfix_r ? e1_zval_r : (fin == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      e1_v_r <= e1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  assign out_valid  = o_v_r;
  assign out_result = o_res_r;
  assign out_wb     = o_wb_r;
  assign out_zf     = o_zf_r;
  assign out_dz     = o_dz_r;

endmodule

@@ sv/integer_alu_with_zero_flag.sv @@
// ----------------------------------------------------------------------------
// integer_alu_with_zero_flag - 64-bit integer ALU with zero flag
// Front end queues classified operations; back end executes them in order.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser
//  in_     | in  | [63:0] operand_a [127:64] b   | [4:0] func
//  out_    | out | [63:0] result_value          | [0] write_back [1] zero_flag
//          |     |                               | [2] divide_by_zero
//
// Add, sub, logic, shift and compare beats: one beat per cycle while the
// divider is idle and the output is not stalled; each passes through the queue,
// the stage 1 register and the output register. Multiply likewise, split into
// three 32x32 partial products in the first execute stage, summed in the second.
// Divide and remainder run in the one-bit-per-cycle divider, which takes no new
// beat and holds the queue until its result moves on; a zero divisor skips it.
// Reset (rst_n low, synchronous) empties the queue and the pipe.
// A stalled output holds; the input keeps taking beats until the queue fills.
// ----------------------------------------------------------------------------
module integer_alu_with_zero_flag #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] operand_a, [127:64] operand_b
  input  logic [4:0]   in_tuser,   // [4:0] func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // [63:0] result_value
  output logic [2:0]   out_tuser   // [0] write_back, [1] zero_flag, [2] divide_by_zero
);

  logic              q_valid, q_pop;
  iaz_pkg::q_entry_t q_head;

  iaz_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_a     (in_tdata[63:0]),
    .in_b     (in_tdata[127:64]),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  iaz_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_head     (q_head),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_tdata),
    .out_wb     (out_tuser[0]),
    .out_zf     (out_tuser[1]),
    .out_dz     (out_tuser[2])
  );

endmodule

@@ sv/iaz_checker.sv @@
// ----------------------------------------------------------------------------
// iaz_checker - port-level checks for the integer ALU
// Watches the output channel; bound to the top level.
// ----------------------------------------------------------------------------
module iaz_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_dz_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == 64'd0 && out_tuser[1] && out_tuser[0])
    else $error("divide-by-zero beat malformed");

  a_nowb_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 64'd0 && !out_tuser[2])
    else $error("compare beat carries data");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind integer_alu_with_zero_flag iaz_checker u_iaz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
